// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the scanner modules.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every edge.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/its_pkg.sv -----
// ----------------------------------------------------------------------------
// its_pkg
// Types, character codes and sizes shared by the INI token scanner modules.
// ----------------------------------------------------------------------------
package its_pkg;

  localparam int CntW   = 24;  // position and line counter width (8..32)
  localparam int FieldW = 24;  // width of offset, length and line fields
  localparam int QDepth = 4;   // result queue entries
  localparam int QAw    = $clog2(QDepth);

  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [CntW:0]     lenx_t;
  typedef logic [FieldW-1:0] field_t;

  localparam cnt_t CntMax = {CntW{1'b1}};

  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChRbr   = 8'h5D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef enum logic [3:0] {
    K_EQUAL    = 4'd0,
    K_LBRACKET = 4'd1,
    K_RBRACKET = 4'd2,
    K_IDENT    = 4'd3,
    K_STRING   = 4'd4,
    K_INTEGER  = 4'd5,
    K_FLOAT    = 4'd6,
    K_END      = 4'd7,
    K_ERROR    = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    E_COMMENT_OPEN  = 2'd0,
    E_COMMENT_START = 2'd1,
    E_SYMBOL        = 2'd2,
    E_STRING_OPEN   = 2'd3
  } err_e;

  typedef enum logic [10:0] {
    M_IDLE      = 11'b000_0000_0001,
    M_IDENT     = 11'b000_0000_0010,
    M_NUMBER    = 11'b000_0000_0100,
    M_NUMDOT    = 11'b000_0000_1000,
    M_FRAC      = 11'b000_0001_0000,
    M_STRING    = 11'b000_0010_0000,
    M_SLASH     = 11'b000_0100_0000,
    M_LINECOM   = 11'b000_1000_0000,
    M_BLOCK     = 11'b001_0000_0000,
    M_BLOCKSTAR = 11'b010_0000_0000,
    M_HALT      = 11'b100_0000_0000
  } mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    kind_e  token_kind;
    err_e   error_code;
    field_t token_start;
    field_t token_length;
    field_t line_number;
    logic   last;
  } tok_t;

  // Results produced by one accepted item, in order.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       r0;
    tok_t       r1;
  } push_t;

endpackage

// ----- sv/its_front.sv -----
// ----------------------------------------------------------------------------
// its_front
// Scanner state machine: takes one byte a beat, tracks position and line,
// and hands zero to two finished tokens to the result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module its_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  its_pkg::in_t   in_data_i,
  output logic           in_stall_o,
  input  logic           room_i,
  output its_pkg::push_t push_o
);

  its_pkg::mode_e mode_q, mode_d;
  its_pkg::cnt_t  pos_q, pos_d, beg_q, beg_d, line_q, line_d;

  logic acc;

  logic           is_dig, is_alp;
  logic           bb_emit, bb_inc;
  its_pkg::mode_e bb_mode;
  its_pkg::tok_t  bb_tok;

  logic          p0_v, p1_v, do_begin;
  its_pkg::tok_t p0, p1, r0, r1;
  logic [1:0]    n;

  its_pkg::cnt_t pos_inc, line_inc, span_p, dot_p, span_dot;

  function automatic its_pkg::tok_t mk(its_pkg::kind_e k, its_pkg::err_e e,
                                       its_pkg::cnt_t s, its_pkg::lenx_t l,
                                       its_pkg::cnt_t ln);
    its_pkg::tok_t t;
    t.token_kind   = k;
    t.error_code   = e;
    t.token_start  = its_pkg::field_t'(s);
    t.token_length = its_pkg::field_t'(l);
    t.line_number  = its_pkg::field_t'(ln);
    t.last         = 1'b0;
    return t;
  endfunction

  assign acc        = in_valid_i && room_i;
  assign in_stall_o = !room_i;

  assign pos_inc  = (pos_q == its_pkg::CntMax) ? pos_q : pos_q + its_pkg::cnt_t'(1);
  assign line_inc = (line_q == its_pkg::CntMax) ? line_q : line_q + its_pkg::cnt_t'(1);
  assign span_p   = (pos_q >= beg_q) ? pos_q - beg_q : '0;
  assign dot_p    = (pos_q > beg_q) ? pos_q - its_pkg::cnt_t'(1) : beg_q;
  assign span_dot = dot_p - beg_q;

  // Classify the byte as the first byte of a new lexeme.
  always_comb begin
    is_dig  = in_data_i.ch inside {[8'h30:8'h39]};
    is_alp  = in_data_i.ch inside {[8'h61:8'h7A], [8'h41:8'h5A], its_pkg::ChUnder};
    bb_emit = 1'b0;
    bb_inc  = 1'b0;
    bb_mode = its_pkg::M_IDLE;
    bb_tok  = mk(its_pkg::K_EQUAL, its_pkg::E_COMMENT_OPEN, pos_q,
                 its_pkg::lenx_t'(1), line_q);
    case (in_data_i.ch)
      its_pkg::ChEq: bb_emit = 1'b1;
      its_pkg::ChLbr: begin
        bb_emit = 1'b1;
        bb_tok.token_kind = its_pkg::K_LBRACKET;
      end
      its_pkg::ChRbr: begin
        bb_emit = 1'b1;
        bb_tok.token_kind = its_pkg::K_RBRACKET;
      end
      its_pkg::ChSlash: bb_mode = its_pkg::M_SLASH;
      its_pkg::ChSp, its_pkg::ChCr, its_pkg::ChTab: ;
      its_pkg::ChNl: bb_inc = 1'b1;
      its_pkg::ChNul: begin
        bb_emit = 1'b1;
        bb_tok.token_kind = its_pkg::K_END;
      end
      its_pkg::ChQuote: bb_mode = its_pkg::M_STRING;
      default: begin
        if (is_dig) begin
          bb_mode = its_pkg::M_NUMBER;
        end else if (is_alp) begin
          bb_mode = its_pkg::M_IDENT;
        end else begin
          bb_emit = 1'b1;
          bb_mode = its_pkg::M_HALT;
          bb_tok  = mk(its_pkg::K_ERROR, its_pkg::E_SYMBOL, pos_q,
                       its_pkg::lenx_t'(0), line_q);
        end
      end
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    beg_d    = beg_q;
    line_d   = line_q;
    p0_v     = 1'b0;
    p1_v     = 1'b0;
    do_begin = 1'b0;
    p0       = mk(its_pkg::K_END, its_pkg::E_COMMENT_OPEN, pos_q,
                  its_pkg::lenx_t'(0), line_q);
    p1       = p0;
    r0       = p0;
    r1       = p0;
    n        = 2'd0;

    if (in_data_i.end_of_input) begin
      // Flush the pending lexeme, then the end token unless an error stops it.
      case (mode_q)
        its_pkg::M_HALT: ;
        its_pkg::M_IDENT, its_pkg::M_NUMBER, its_pkg::M_FRAC: begin
          p0_v = 1'b1;
          p1_v = 1'b1;
          p0   = mk((mode_q == its_pkg::M_IDENT) ? its_pkg::K_IDENT :
                    (mode_q == its_pkg::M_FRAC) ? its_pkg::K_FLOAT : its_pkg::K_INTEGER,
                    its_pkg::E_COMMENT_OPEN, beg_q, its_pkg::lenx_t'(span_p), line_q);
        end
        its_pkg::M_NUMDOT: begin
          p0_v = 1'b1;
          p1_v = 1'b1;
          p0   = mk(its_pkg::K_INTEGER, its_pkg::E_COMMENT_OPEN, beg_q,
                    its_pkg::lenx_t'(span_dot), line_q);
          p1   = mk(its_pkg::K_ERROR, its_pkg::E_SYMBOL, dot_p,
                    its_pkg::lenx_t'(0), line_q);
        end
        its_pkg::M_STRING: begin
          p0_v = 1'b1;
          p0   = mk(its_pkg::K_ERROR, its_pkg::E_STRING_OPEN, beg_q,
                    its_pkg::lenx_t'(0), line_q);
        end
        its_pkg::M_SLASH: begin
          p0_v = 1'b1;
          p0   = mk(its_pkg::K_ERROR, its_pkg::E_COMMENT_START, beg_q,
                    its_pkg::lenx_t'(0), line_q);
        end
        its_pkg::M_BLOCK, its_pkg::M_BLOCKSTAR: begin
          p0_v = 1'b1;
          p0   = mk(its_pkg::K_ERROR, its_pkg::E_COMMENT_OPEN, beg_q,
                    its_pkg::lenx_t'(0), line_q);
        end
        default: p0_v = 1'b1;  // idle or line comment: end token only
      endcase
      mode_d = its_pkg::M_IDLE;
      pos_d  = '0;
      beg_d  = '0;
      line_d = '0;
    end else begin
      pos_d = pos_inc;
      case (mode_q)
        its_pkg::M_HALT: ;
        its_pkg::M_IDENT: begin
          if (!(is_alp || is_dig)) begin
            p0_v     = 1'b1;
            p0       = mk(its_pkg::K_IDENT, its_pkg::E_COMMENT_OPEN, beg_q,
                          its_pkg::lenx_t'(span_p), line_q);
            do_begin = 1'b1;
          end
        end
        its_pkg::M_NUMBER: begin
          if (in_data_i.ch == its_pkg::ChDot) begin
            mode_d = its_pkg::M_NUMDOT;
          end else if (!is_dig) begin
            p0_v     = 1'b1;
            p0       = mk(its_pkg::K_INTEGER, its_pkg::E_COMMENT_OPEN, beg_q,
                          its_pkg::lenx_t'(span_p), line_q);
            do_begin = 1'b1;
          end
        end
        its_pkg::M_NUMDOT: begin
          if (is_dig) begin
            mode_d = its_pkg::M_FRAC;
          end else begin
            // Integer without the dot, then the dot as a stray symbol.
            p0_v   = 1'b1;
            p1_v   = 1'b1;
            p0     = mk(its_pkg::K_INTEGER, its_pkg::E_COMMENT_OPEN, beg_q,
                        its_pkg::lenx_t'(span_dot), line_q);
            p1     = mk(its_pkg::K_ERROR, its_pkg::E_SYMBOL, dot_p,
                        its_pkg::lenx_t'(0), line_q);
            mode_d = its_pkg::M_HALT;
          end
        end
        its_pkg::M_FRAC: begin
          if (!is_dig) begin
            p0_v     = 1'b1;
            p0       = mk(its_pkg::K_FLOAT, its_pkg::E_COMMENT_OPEN, beg_q,
                          its_pkg::lenx_t'(span_p), line_q);
            do_begin = 1'b1;
          end
        end
        its_pkg::M_STRING: begin
          if (in_data_i.ch == its_pkg::ChQuote) begin
            p0_v   = 1'b1;
            p0     = mk(its_pkg::K_STRING, its_pkg::E_COMMENT_OPEN, beg_q,
                        its_pkg::lenx_t'(span_p) + its_pkg::lenx_t'(1), line_q);
            mode_d = its_pkg::M_IDLE;
          end else if (in_data_i.ch == its_pkg::ChNl) begin
            line_d = line_inc;
          end
        end
        its_pkg::M_SLASH: begin
          if (in_data_i.ch == its_pkg::ChSlash) begin
            mode_d = its_pkg::M_LINECOM;
          end else if (in_data_i.ch == its_pkg::ChStar) begin
            mode_d = its_pkg::M_BLOCK;
          end else begin
            p0_v   = 1'b1;
            p0     = mk(its_pkg::K_ERROR, its_pkg::E_COMMENT_START, beg_q,
                        its_pkg::lenx_t'(0), line_q);
            mode_d = its_pkg::M_HALT;
          end
        end
        its_pkg::M_LINECOM: begin
          if (in_data_i.ch == its_pkg::ChNl) begin
            line_d = line_inc;
            mode_d = its_pkg::M_IDLE;
          end
        end
        its_pkg::M_BLOCK: begin
          if (in_data_i.ch == its_pkg::ChStar) begin
            mode_d = its_pkg::M_BLOCKSTAR;
          end else if (in_data_i.ch == its_pkg::ChNl) begin
            line_d = line_inc;
          end
        end
        its_pkg::M_BLOCKSTAR: begin
          if (in_data_i.ch == its_pkg::ChSlash) begin
            mode_d = its_pkg::M_IDLE;
          end else if (in_data_i.ch != its_pkg::ChStar) begin
            if (in_data_i.ch == its_pkg::ChNl) begin
              line_d = line_inc;
            end
            mode_d = its_pkg::M_BLOCK;
          end
        end
        default: do_begin = 1'b1;  // idle
      endcase

      if (do_begin) begin
        beg_d  = pos_q;
        mode_d = bb_mode;
        if (bb_inc) begin
          line_d = line_inc;
        end
      end
    end

    // Pack results in order; the new lexeme's token follows the flushed one.
    if (p0_v) begin
      r0 = p0;
      if (p1_v) begin
        r1 = p1;
        n  = 2'd2;
      end else if (do_begin && bb_emit) begin
        r1 = bb_tok;
        n  = 2'd2;
      end else begin
        n = 2'd1;
      end
    end else if (do_begin && bb_emit) begin
      r0 = bb_tok;
      n  = 2'd1;
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;

    push_o.cnt = acc ? n : 2'd0;
    push_o.r0  = r0;
    push_o.r1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= its_pkg::M_IDLE;
      pos_q  <= '0;
      beg_q  <= '0;
      line_q <= '0;
    end else if (acc) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      beg_q  <= beg_d;
      line_q <= line_d;
    end
  end

  `ASSERT_IMPLY(a_halt_silent, acc && !in_data_i.end_of_input && mode_q == its_pkg::M_HALT, push_o.cnt == 2'd0)
  `ASSERT_NEXT(a_eoi_restart, acc && in_data_i.end_of_input, mode_q == its_pkg::M_IDLE && pos_q == '0 && line_q == '0)

endmodule

// ----- sv/its_queue.sv -----
// ----------------------------------------------------------------------------
// its_queue
// Small result queue: takes up to two results a cycle from the scanner while it
// has room, and gives one a cycle to the output stage when that stage pops it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module its_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  its_pkg::push_t push_i,
  output logic           room_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output its_pkg::tok_t  head_o
);

  localparam logic [its_pkg::QAw:0] CntLim  = (its_pkg::QAw + 1)'(its_pkg::QDepth);
  localparam logic [its_pkg::QAw:0] RoomLim = (its_pkg::QAw + 1)'(its_pkg::QDepth - 2);

  its_pkg::tok_t             mem_q [its_pkg::QDepth];
  logic [its_pkg::QAw-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [its_pkg::QAw:0]     cnt_q, cnt_d;

  // Room for the worst case of two results from the next beat.
  assign room_o       = (cnt_q <= RoomLim);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];

  assign wr_d  = wr_q + its_pkg::QAw'(push_i.cnt);
  assign rd_d  = rd_q + its_pkg::QAw'(pop_i);
  assign cnt_d = cnt_q + (its_pkg::QAw + 1)'(push_i.cnt) - (its_pkg::QAw + 1)'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + its_pkg::QAw'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntLim)
  `ASSERT_IMPLY(a_push_room, push_i.cnt != 2'd0, cnt_q <= RoomLim)
  `ASSERT_IMPLY(a_no_pop_empty, pop_i, cnt_q != '0)

endmodule

// ----- sv/its_out.sv -----
// ----------------------------------------------------------------------------
// its_out
// Output register: pulls the queue head and presents it until taken.
// ----------------------------------------------------------------------------
module its_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  its_pkg::tok_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output its_pkg::tok_t out_data_o
);

  logic          valid_q, valid_d;
  its_pkg::tok_t data_q;

  // Load when the register is empty or its beat leaves this cycle.
  assign pop_o   = head_valid_i && (!valid_q || !out_stall_i);
  assign valid_d = pop_o ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- sv/ini_token_scanner.sv -----
// ----------------------------------------------------------------------------
// ini_token_scanner
// Streaming INI lexer: one source byte a beat in, tokens with offset, length
// and line out, through a scanner, a result queue and an output register.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the input is not stalled; a byte that
//   yields two tokens sends them out one at a time, absorbed by the four-entry result queue.
// A token passes through the result queue and then the output register before it is valid.
// Input stalls whenever the queue could not take two more tokens.
// Reset (async, active low) clears the scanner mode, counters, queue and
//   output valid; no clearing pass is needed.
module ini_token_scanner (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  its_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output its_pkg::tok_t out_data_o
);

  its_pkg::push_t push;
  logic           room, pop, head_valid;
  its_pkg::tok_t  head;

  its_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .room_i     (room),
    .push_o     (push)
  );

  its_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .room_o       (room),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  its_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
